[rtl/vt100_line_editor_with_history_assert.svh]
// Assertion macros for the line editor.
`ifndef VT100_LINE_EDITOR_WITH_HISTORY_ASSERT_SVH
`define VT100_LINE_EDITOR_WITH_HISTORY_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VLE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VLE_ASSERT(label, clk, rst_n, prop, msg)
`define VLE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/vle_pkg.sv]
// Package with shared types and constants of the line editor.
`timescale 1ns / 1ps
package vle_pkg;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_HI  = 8'h80;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_SHOUT  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } cell_ctl_t;
endpackage

[rtl/vle_cell.sv]
// One character cell of the line row, with its history column.
`timescale 1ns / 1ps
module vle_cell #(
  parameter int HIST = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vle_pkg::cell_ctl_t    ctl,
  input  logic                  at_ins,
  input  logic                  past_ins,
  input  logic                  past_rem,
  input  logic                  tail,
  input  logic [7:0]            left_ch,
  input  logic [7:0]            right_ch,
  input  logic                  hist_push,
  input  logic                  save,
  input  logic [HIST:0]         load_sel,
  output logic [7:0]            ch,
  output logic [7:0]            newest
);
  import vle_pkg::*;
  logic [7:0] line_r, line_nxt;
  logic [7:0] hist_r [HIST+1];
  logic [7:0] ld;

  always_comb begin
    ld = 8'd0;
    for (int k = 0; k <= HIST; k++) if (load_sel[k]) ld = hist_r[k];
  end

  always_comb begin
    line_nxt = line_r;
    case (ctl.op)
      OP_INSERT: begin
        if (at_ins) line_nxt = ctl.ch;
        else if (past_ins) line_nxt = left_ch;
      end
      OP_REMOVE: begin
        if (tail) line_nxt = 8'd0;
        else if (past_rem) line_nxt = right_ch;
      end
      OP_LOAD: line_nxt = ld;
      OP_CLEAR: line_nxt = 8'd0;
      OP_SHOUT: line_nxt = right_ch;
      default: line_nxt = line_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 8'd0;
      for (int k = 0; k <= HIST; k++) hist_r[k] <= 8'd0;
    end else begin
      line_r <= line_nxt;
      if (save) hist_r[0] <= line_r;
      if (hist_push) begin
        hist_r[1] <= line_r;
        for (int k = 2; k <= HIST; k++) hist_r[k] <= hist_r[k-1];
      end
      if (ctl.op == OP_CLEAR) hist_r[0] <= 8'd0;
    end
  end
  assign ch = line_r;
  assign newest = hist_r[1];
endmodule

[rtl/vt100_line_editor_with_history.sv]
// Top level: VT100 line editor with history over a row of character cells.
//
// Input stream in_*: one request per received byte (tuser = 0) or gap tick
// (tuser = 1); tdata carries the byte. Output stream out_*: results with
// tuser = kind, tlast = last of the run, tdata = {history_pos, length,
// cursor, line_char}. A byte gives one status result; return gives one
// character result per line character, then an end result.
// A status result is valid in the cycle after the accept; the first character
// of a return is loaded in the shift state entered on the accept. Each byte is
// decoded and edited, then presented, before the next byte is taken; on return
// the row shifts one character per cycle to cell 0 while the output is not
// stalled. Return first compares the line with the newest history entry over
// all cells; a non-empty line that differs is pushed into the history columns.
// Reset clears the row, the history and all control state at once.
// A stalled receiver holds the output register; no input is taken until
// the last result of the run is taken.
`timescale 1ns / 1ps
module vt100_line_editor_with_history #(
  parameter int LINE_BYTES = 64,
  parameter int HISTORY_LINES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // line_char[7:0], cursor[13:8], length[19:14], history_pos[22:20]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last
);
  import vle_pkg::*;
  `include "vt100_line_editor_with_history_assert.svh"

  localparam int HIST = HISTORY_LINES - 1;
  localparam int LW = $clog2(LINE_BYTES);
  localparam int HW = $clog2(HISTORY_LINES);
  localparam int MAXC = LINE_BYTES - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OUT  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [LW-1:0] cur_r, cur_nxt, len_r, len_nxt, slen_r, slen_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] hlen_r [HIST];
  logic [HW-1:0] hidx_r, hidx_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [7:0] e0_r, e0_nxt, e1_r, e1_nxt;
  logic ov_r;
  logic [1:0] okind_r;
  logic [7:0] och_r;
  logic [LW-1:0] ocur_r, olen_r;
  logic [HW-1:0] ohp_r;
  logic olast_r;

  cell_ctl_t ctl;
  logic [7:0] chs [LINE_BYTES];
  logic [7:0] newest [LINE_BYTES];
  logic [HIST:0] load_sel;
  logic save, push;
  logic [LW-1:0] ins_pos, rem_pos, ins_top;
  logic eq_all, eq_cell [LINE_BYTES];

  logic acc, b_ret, b_chr, b_bk, b_del, b_up, b_dn, b_lf, b_rt, b_hm, b_en;
  logic [7:0] b;
  logic [HW-1:0] h;
  logic [LW-1:0] ld_len;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign b = in_tdata;

  always_comb begin
    ph_nxt = ph_r; e0_nxt = e0_r; e1_nxt = e1_r;
    {b_ret, b_chr, b_bk, b_del, b_up, b_dn, b_lf, b_rt, b_hm, b_en} = '0;
    if (in_tuser) ph_nxt = 2'd0;
    else begin
      case (ph_r)
        2'd1: begin e0_nxt = b; ph_nxt = 2'd2; end
        2'd2: begin
          e1_nxt = b; ph_nxt = 2'd0;
          if (e0_r == "O") begin
            b_hm = b == "H"; b_en = b == "F";
          end else if (e0_r == "[") begin
            if (b >= "0" && b <= "9") ph_nxt = 2'd3;
            b_up = b == "A"; b_dn = b == "B"; b_rt = b == "C"; b_lf = b == "D";
            b_hm = b == "H"; b_en = b == "F";
          end
        end
        2'd3: begin
          ph_nxt = 2'd0;
          if (b == "~") begin
            b_del = e1_r == "3";
            b_hm = e1_r == "1" || e1_r == "7";
            b_en = e1_r == "4" || e1_r == "8";
          end
        end
        default: begin
          ph_nxt = 2'd0;
          if (b == CH_ESC) ph_nxt = 2'd1;
          else if (b <= CH_HI) begin
            b_bk = b == CH_DEL || b == CH_BS;
            b_ret = b == CH_CR || b == CH_LF;
            b_chr = !b_bk && !b_ret && b != 8'h04 && b != 8'h09;
          end
        end
      endcase
    end
  end

  always_comb begin
    h = hidx_r;
    if (hidx_r != HW'(HIST)) h = hidx_r + HW'(1);
    if (hlen_r[h - HW'(1)] == '0) h = h - HW'(1);
  end

  always_comb begin
    eq_all = (len_r == hlen_r[0]);
    for (int i = 0; i < LINE_BYTES; i++) eq_all = eq_all && eq_cell[i];
  end

  always_comb begin
    st_nxt = st_r; cur_nxt = cur_r; len_nxt = len_r; slen_nxt = slen_r;
    hidx_nxt = hidx_r; cnt_nxt = cnt_r;
    ctl.op = OP_HOLD; ctl.ch = b;
    load_sel = '0; save = 1'b0; push = 1'b0;
    ins_pos = cur_r; rem_pos = cur_r;
    ins_top = (len_r < LW'(MAXC)) ? len_r : LW'(MAXC - 1);
    ld_len = '0;
    case (st_r)
      ST_IDLE: if (acc && !in_tuser) begin
        st_nxt = ST_OUT;
        if (b_ret) begin
          st_nxt = ST_SHIFT; cnt_nxt = len_r;
          push = (len_r != '0) && !eq_all;
          cur_nxt = '0; hidx_nxt = '0; slen_nxt = '0;
        end else if (b_chr) begin
          if (cur_r < LW'(MAXC)) begin
            ctl.op = OP_INSERT; cur_nxt = cur_r + LW'(1);
            if (len_r < LW'(MAXC)) len_nxt = len_r + LW'(1);
          end
        end else if (b_bk) begin
          if (cur_r != '0) begin
            ctl.op = OP_REMOVE; rem_pos = cur_r - LW'(1);
            cur_nxt = cur_r - LW'(1); len_nxt = len_r - LW'(1);
          end
        end else if (b_del) begin
          if (cur_r < len_r) begin ctl.op = OP_REMOVE; len_nxt = len_r - LW'(1); end
        end else if (b_lf) begin
          if (cur_r != '0) cur_nxt = cur_r - LW'(1);
        end else if (b_rt) begin
          if (cur_r < len_r) cur_nxt = cur_r + LW'(1);
        end else if (b_hm) cur_nxt = '0;
        else if (b_en) cur_nxt = len_r;
        else if (b_up) begin
          if (hidx_r == '0) begin save = 1'b1; slen_nxt = len_r; end
          hidx_nxt = h;
          if (h != '0) begin
            ctl.op = OP_LOAD; load_sel[h] = 1'b1;
            len_nxt = hlen_r[h - HW'(1)]; cur_nxt = len_nxt;
          end else cur_nxt = len_r;
        end else if (b_dn) begin
          hidx_nxt = (hidx_r != '0) ? hidx_r - HW'(1) : hidx_r;
          ctl.op = OP_LOAD; load_sel[hidx_nxt] = 1'b1;
          ld_len = (hidx_nxt == '0) ? slen_r : hlen_r[hidx_nxt - HW'(1)];
          if (hidx_r == '0) ld_len = slen_r;
          len_nxt = ld_len; cur_nxt = ld_len;
        end
      end
      ST_SHIFT: if (!ov_r || out_tready) begin
        if (cnt_r == '0) begin
          st_nxt = ST_OUT; ctl.op = OP_CLEAR; len_nxt = '0;
        end else begin
          ctl.op = OP_SHOUT; cnt_nxt = cnt_r - LW'(1);
        end
      end
      ST_OUT: if (!ov_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < LINE_BYTES; i++) begin : g_row
    logic [7:0] rc;
    logic [LW-1:0] hl0;
    assign rc = (i == LINE_BYTES - 1) ? 8'd0 : chs[(i + 1) % LINE_BYTES];
    vle_cell #(.HIST(HIST)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .at_ins(LW'(i) == ins_pos),
      .past_ins(LW'(i) > ins_pos && LW'(i) <= ins_top),
      .past_rem(LW'(i) >= rem_pos),
      .tail(LW'(i) >= len_r - LW'(1)),
      .left_ch(chs[(i + LINE_BYTES - 1) % LINE_BYTES]),
      .right_ch(rc), .hist_push(push), .save(save),
      .load_sel(load_sel), .ch(chs[i]), .newest(newest[i])
    );
    assign hl0 = hlen_r[0];
    assign eq_cell[i] = (LW'(i) >= hl0) || (chs[i] == newest[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cur_r <= '0; len_r <= '0; slen_r <= '0; cnt_r <= '0;
      hidx_r <= '0; ph_r <= '0; e0_r <= '0; e1_r <= '0; ov_r <= 1'b0;
      okind_r <= KIND_STATUS; och_r <= '0; olast_r <= 1'b0;
      ocur_r <= '0; olen_r <= '0; ohp_r <= '0;
      for (int k = 0; k < HIST; k++) hlen_r[k] <= '0;
    end else begin
      st_r <= st_nxt; cur_r <= cur_nxt; len_r <= len_nxt; slen_r <= slen_nxt;
      cnt_r <= cnt_nxt; hidx_r <= hidx_nxt;
      if (acc) begin ph_r <= ph_nxt; e0_r <= e0_nxt; e1_r <= e1_nxt; end
      if (push) begin
        hlen_r[0] <= len_r;
        for (int k = 1; k < HIST; k++) hlen_r[k] <= hlen_r[k-1];
      end
      if (st_r == ST_SHIFT && (!ov_r || out_tready)) begin
        ov_r <= 1'b1;
        okind_r <= (cnt_r == '0) ? KIND_END : KIND_CHAR;
        och_r <= (cnt_r == '0) ? 8'd0 : chs[0];
        olast_r <= cnt_r == '0;
        ocur_r <= '0; olen_r <= '0; ohp_r <= '0;
      end else if (acc && !in_tuser && !b_ret) begin
        ov_r <= 1'b1; okind_r <= KIND_STATUS; och_r <= 8'd0; olast_r <= 1'b1;
        ocur_r <= cur_nxt; olen_r <= len_nxt; ohp_r <= hidx_nxt;
      end else if (out_tvalid && out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser = okind_r;
  assign out_tlast = olast_r;
  assign out_tdata = {1'b0, 3'(ohp_r), 6'(olen_r), 6'(ocur_r), och_r};

  `VLE_ASSERT(a_cur_le_len, clk, rst_n, cur_r <= len_r, "cursor beyond line end")
  `VLE_ASSERT(a_no_acc_busy, clk, rst_n, (st_r != ST_IDLE) |-> !in_tready, "accept while busy")
  `VLE_ASSERT(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> $stable(out_tdata), "result changed while stalled")
endmodule

[dv/tb_vt100_line_editor_with_history.sv]
// Testbench for the VT100 line editor: key decoding, line edits, history recall and line output.
`timescale 1ns / 1ps
module tb_vt100_line_editor_with_history;
  import vle_pkg::*;

  localparam int LINE_MAX  = 63;
  localparam int HIST_MAX  = 7;
  localparam int WATCH_MAX = 20000;

  typedef enum int {
    KEY_NONE, KEY_CHAR, KEY_BKSPC, KEY_DEL, KEY_RET, KEY_UP, KEY_DOWN,
    KEY_LEFT, KEY_RIGHT, KEY_HOME, KEY_END
  } key_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_char;
    logic [5:0] cursor;
    logic [5:0] length;
    logic [2:0] history_pos;
    logic       last;
  } editor_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  always #1 clk = ~clk;

  vt100_line_editor_with_history i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // editor model state
  logic [7:0] ed_line [64];
  int         ed_len;
  logic [7:0] ed_hist [HIST_MAX][64];
  int         ed_hist_len [HIST_MAX];
  logic [7:0] ed_saved [64];
  int         ed_saved_len;
  int         ed_cursor;
  int         ed_hpos;
  int         esc_phase;
  logic [7:0] esc_bytes [2];

  editor_result_t expected_results [$];
  int  error_count = 0;
  int  idle_pct = 33;
  bit  hold_req = 1'b0;
  bit  rx_hold = 1'b0;
  int  idle_cycles = 0;
  int  results_seen = 0;
  int  lines_seen = 0;

  function automatic key_e decode_key(logic [7:0] b);
    case (esc_phase)
      1: begin
        esc_bytes[0] = b;
        esc_phase = 2;
        return KEY_NONE;
      end
      2: begin
        esc_bytes[1] = b;
        esc_phase = 0;
        if (esc_bytes[0] == "O") begin
          if (b == "H") return KEY_HOME;
          if (b == "F") return KEY_END;
          return KEY_NONE;
        end
        if (esc_bytes[0] != "[") return KEY_NONE;
        if (b >= "0" && b <= "9") begin
          esc_phase = 3;
          return KEY_NONE;
        end
        case (b)
          "A": return KEY_UP;
          "B": return KEY_DOWN;
          "C": return KEY_RIGHT;
          "D": return KEY_LEFT;
          "H": return KEY_HOME;
          "F": return KEY_END;
          default: return KEY_NONE;
        endcase
      end
      3: begin
        esc_phase = 0;
        if (b != "~") return KEY_NONE;
        case (esc_bytes[1])
          "3": return KEY_DEL;
          "1", "7": return KEY_HOME;
          "4", "8": return KEY_END;
          default: return KEY_NONE;
        endcase
      end
      default: begin
        esc_phase = 0;
        if (b == CH_ESC) begin
          esc_phase = 1;
          return KEY_NONE;
        end
        if (b > CH_HI) return KEY_NONE;
        case (b)
          CH_DEL, CH_BS: return KEY_BKSPC;
          CH_LF, CH_CR: return KEY_RET;
          8'h04, 8'h09: return KEY_NONE;
          default: return KEY_CHAR;
        endcase
      end
    endcase
  endfunction

  function automatic void load_entry(int e);
    for (int i = 0; i < 64; i++) ed_line[i] = (e == 0) ? ed_saved[i] : ed_hist[e-1][i];
    ed_len = (e == 0) ? ed_saved_len : ed_hist_len[e-1];
    ed_cursor = ed_len;
  endfunction

  function automatic void remove_char(int pos);
    if (pos >= ed_len) return;
    for (int i = pos; i + 1 < ed_len; i++) ed_line[i] = ed_line[i+1];
    ed_len--;
    ed_line[ed_len] = '0;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] ch, logic last);
    editor_result_t r;
    r.kind = kind;
    r.line_char = ch;
    r.cursor = ed_cursor[5:0];
    r.length = ed_len[5:0];
    r.history_pos = ed_hpos[2:0];
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_editor(logic gap, logic [7:0] b);
    key_e k;
    int h, n;
    bit same;
    logic [7:0] buf_line [64];
    if (gap) begin
      esc_phase = 0;
      return;
    end
    k = decode_key(b);
    case (k)
      KEY_RET: begin
        n = ed_len;
        buf_line = ed_line;
        same = (ed_hist_len[0] == ed_len);
        for (int i = 0; i < ed_len; i++) if (ed_hist[0][i] != ed_line[i]) same = 0;
        if (ed_len > 0 && !same) begin
          for (int e = HIST_MAX - 1; e > 0; e--) begin
            ed_hist[e] = ed_hist[e-1];
            ed_hist_len[e] = ed_hist_len[e-1];
          end
          ed_hist[0] = ed_line;
          ed_hist_len[0] = ed_len;
        end
        for (int i = 0; i < 64; i++) begin
          ed_line[i] = '0;
          ed_saved[i] = '0;
        end
        ed_len = 0;
        ed_saved_len = 0;
        ed_cursor = 0;
        ed_hpos = 0;
        for (int i = 0; i < n; i++) push_result(KIND_CHAR, buf_line[i], 1'b0);
        push_result(KIND_END, 8'h00, 1'b1);
        return;
      end
      KEY_CHAR: if (ed_cursor < LINE_MAX) begin
        for (int i = (ed_len < LINE_MAX) ? ed_len : LINE_MAX - 1; i > ed_cursor; i--)
          ed_line[i] = ed_line[i-1];
        ed_line[ed_cursor] = b;
        ed_cursor++;
        if (ed_len < LINE_MAX) ed_len++;
      end
      KEY_BKSPC: if (ed_cursor > 0) begin
        remove_char(ed_cursor - 1);
        ed_cursor--;
      end
      KEY_DEL: remove_char(ed_cursor);
      KEY_LEFT: if (ed_cursor > 0) ed_cursor--;
      KEY_RIGHT: if (ed_cursor < ed_len) ed_cursor++;
      KEY_HOME: ed_cursor = 0;
      KEY_END: ed_cursor = ed_len;
      KEY_UP: begin
        if (ed_hpos == 0) begin
          ed_saved = ed_line;
          ed_saved_len = ed_len;
        end
        h = ed_hpos + 1;
        if (h > HIST_MAX) h = HIST_MAX;
        if (ed_hist_len[h-1] == 0) h--;
        ed_hpos = h;
        if (h > 0) load_entry(h);
        else ed_cursor = ed_len;
      end
      KEY_DOWN: begin
        if (ed_hpos > 0) ed_hpos--;
        load_entry(ed_hpos);
      end
      default: ;
    endcase
    push_result(KIND_STATUS, 8'h00, 1'b1);
  endfunction

  task automatic send_request(logic gap, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= gap;
    in_tdata  <= b;
    predict_editor(gap, b);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_key(logic [7:0] b);
    send_request(1'b0, b);
  endtask

  task automatic send_seq(string s);
    for (int i = 0; i < s.len(); i++) send_key(s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [7:0] random_text();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic send_random_key();
    int r;
    r = $urandom_range(99);
    if (r < 45) send_key(random_text());
    else if (r < 55) send_key(CH_BS);
    else if (r < 58) send_key(CH_DEL);
    else if (r < 64) begin
      send_key(CH_ESC);
      send_key("[");
      send_key(8'($urandom_range(65, 68)));
    end
    else if (r < 68) send_seq($urandom_range(1) ? "\033[3~" : "\033[1~");
    else if (r < 70) send_seq($urandom_range(1) ? "\033OF" : "\033[8~");
    else if (r < 76) send_key($urandom_range(1) ? CH_CR : CH_LF);
    else if (r < 82) send_key(8'($urandom_range(255)));
    else if (r < 86) begin
      send_key(CH_ESC);
      if ($urandom_range(1)) send_key("[");
      send_request(1'b1, 8'($urandom_range(255)));
    end else if (r < 90) send_request(1'b1, 8'($urandom_range(255)));
    else send_key(8'($urandom_range(0, 31)));
  endtask

  task automatic test_escape_keys();
    send_request(1'b1, 8'hff);
    send_seq("abc");
    send_seq("\033[D\033[D\033OH\033OF\033[H\033[F\033[1~\033[7~\033[4~\033[8~");
    send_seq("\033[D\033[3~\033[3~\033[C\033[C\033[5~\033[9x\033Ox\033xy");
    send_key(CH_ESC);
    send_request(1'b1, 8'h00);
    send_seq("\033[");
    send_request(1'b1, 8'h00);
    send_seq("\033[2");
    send_request(1'b1, 8'h00);
    send_key(CH_CR);
  endtask

  task automatic test_edit_extremes();
    logic [7:0] odd_bytes [10];
    odd_bytes = '{8'h00, 8'h80, 8'h81, 8'hff, 8'h04, 8'h09, 8'h7e, 8'h1f, 8'h55, 8'haa};
    send_key(CH_BS);
    send_seq("\033[3~\033[D\033[C");
    foreach (odd_bytes[i]) send_key(odd_bytes[i]);
    send_key(CH_DEL);
    send_key(CH_LF);
    for (int i = 0; i < 66; i++) send_key(random_text());
    send_seq("\033[H");
    send_key("x");
    send_seq("\033[F");
    send_key(CH_CR);
  endtask

  task automatic test_history();
    for (int n = 0; n < 9; n++) begin
      send_key(8'("a" + n));
      send_key(CH_CR);
    end
    send_key("i");
    send_key(CH_CR);
    send_seq("zz");
    for (int i = 0; i < 9; i++) send_seq("\033[A");
    send_seq("q\033[A");
    for (int i = 0; i < 8; i++) send_seq("\033[B");
    send_key(CH_CR);
    send_seq("\033[A\033[A");
    send_key(CH_CR);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_random_key();
    wait_drained();
    repeat (5) @(posedge clk);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 33;
      if ($urandom_range(3) == 0) begin
        for (int j = $urandom_range(3, 20); j > 0; j--) send_key(random_text());
        send_key(CH_CR);
      end else begin
        send_random_key();
      end
    end
    idle_pct = 33;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    @(posedge rst_n);
    wait (hold_req);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    editor_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[7:0], out_tdata[13:8], out_tdata[19:14], out_tdata[22:20],
             out_tlast};
      results_seen++;
      if (got.kind == KIND_END) lines_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", got);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind != exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
          error_count++;
        end
        if (got.line_char != exp_r.line_char) begin
          $error("line_char: expected %0h, got %0h", exp_r.line_char, got.line_char);
          error_count++;
        end
        if (got.cursor != exp_r.cursor) begin
          $error("cursor: expected %0d, got %0d", exp_r.cursor, got.cursor);
          error_count++;
        end
        if (got.length != exp_r.length) begin
          $error("length: expected %0d, got %0d", exp_r.length, got.length);
          error_count++;
        end
        if (got.history_pos != exp_r.history_pos) begin
          $error("history_pos: expected %0d, got %0d", exp_r.history_pos, got.history_pos);
          error_count++;
        end
        if (got.last != exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, got.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCH_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 64; i++) begin
      ed_line[i] = '0;
      ed_saved[i] = '0;
      for (int e = 0; e < HIST_MAX; e++) ed_hist[e][i] = '0;
    end
    for (int e = 0; e < HIST_MAX; e++) ed_hist_len[e] = 0;
    ed_len = 0;
    ed_saved_len = 0;
    ed_cursor = 0;
    ed_hpos = 0;
    esc_phase = 0;
    esc_bytes[0] = '0;
    esc_bytes[1] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escape_keys();
    test_edit_extremes();
    test_history();
    test_backpressure();
    test_random(40);
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered escape decoding, gap aborts, full-line inserts and history recall;");
    $display("checked %0d results over %0d finished lines.", results_seen, lines_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
